@@ rtl/plid_pkg.sv @@
// Shared constants, types and codes of the packed index table decompressor.
package plid_pkg;

  // Value store geometry (the depth is a power of two; addresses wrap)
  localparam int TABLE_DEPTH   = 1024;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int WORD_W        = 64;

  // Index packing
  localparam int MAX_BIT_WIDTH = 7;
  localparam int BYTE_W        = 8;
  localparam int BW_W          = 3;
  localparam int WID_W         = $clog2(MAX_BIT_WIDTH + 1);
  // bits left over after a byte never reach the index width, so the
  // buffer holds at most one width less one plus a fresh byte
  localparam int BUF_W         = MAX_BIT_WIDTH - 1 + BYTE_W;
  localparam int HELD_W        = $clog2(BUF_W + 1);
  localparam int MAX_RESULTS   = 8;
  localparam int RCNT_W        = $clog2(MAX_RESULTS);

  // Channel and tensor bookkeeping
  localparam int CHAN_W        = 8;
  localparam int CCNT_W        = 9;
  localparam int CHAN_LIMIT    = 256;
  localparam int EPC_W         = 16;
  localparam int STRIDE_W      = 10;
  localparam int TOTAL_W       = 24;
  localparam int TADDR_W       = 10;
  localparam int PROD_W        = CHAN_W + STRIDE_W;

  // Configuration port
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;

  // Queue between front and back
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_TABLE_WRITE = 1'b0,
    CMD_STREAM_BYTE = 1'b1
  } plid_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_WIDTH     = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_ELEMS_PER_CH  = 3'd2,
    REG_TABLE_STRIDE  = 3'd3,
    REG_ALT_AXIS      = 3'd4,
    REG_TOTAL_INDICES = 3'd5
  } plid_reg_e;

  typedef struct packed {
    logic [BW_W-1:0]     bit_width;
    logic [CCNT_W-1:0]   channel_count;
    logic [EPC_W-1:0]    elements_per_channel;
    logic [STRIDE_W-1:0] table_stride;
    logic                alternate_axis;
    logic [TOTAL_W-1:0]  total_indices;
  } plid_cfg_t;

  // One queued operation: a store write or a store read that yields a result
  typedef struct packed {
    plid_cmd_e           kind;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   word;
    logic [CHAN_W-1:0]   chan;
    logic                last_of_byte;
    logic                last_of_tensor;
  } plid_op_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic push;
  } plid_qctl_t;

endpackage

@@ rtl/packed_index_lut_decompressor_top.sv @@
// Top level of the packed index table decompressor.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  in      | to block  | in_valid_i/in_stall_o | command, table_address, table_word,
//          |           |                     | stream_byte
//  out     | from block| out_valid_o/out_stall_i | value, channel, last_of_byte,
//          |           |                     | last_of_tensor
//  cfg     | to block  | cfg_we_i            | cfg_index_i, cfg_data_i
//
// A stream word occupies the front end while it yields its indices (at most 8); the front end
// unpacks one index per cycle while the queue has room. A table write is queued as a single
// store operation. The back end delivers one result per cycle while the output is not stalled;
// a result passes the queue, the store read and the output register after its index is unpacked.
// Reset is asynchronous, active low, and clears all control state and configuration;
// the value store holds no reset value and must be written before it is read.
// A four-entry queue lets the input keep going while the output is stalled.
module packed_index_lut_decompressor_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [plid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [plid_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            in_command_i,
  input  logic [plid_pkg::TADDR_W-1:0]    in_table_address_i,
  input  logic [plid_pkg::WORD_W-1:0]     in_table_word_i,
  input  logic [plid_pkg::BYTE_W-1:0]     in_stream_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [plid_pkg::WORD_W-1:0]     out_value_o,
  output logic [plid_pkg::CHAN_W-1:0]     out_channel_o,
  output logic                            out_last_of_byte_o,
  output logic                            out_last_of_tensor_o
);
  import plid_pkg::*;

  plid_cfg_t   cfg_q, cfg_d;
  plid_qctl_t  qctl;
  plid_op_t    push_op;
  plid_op_t    pop_op;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BIT_WIDTH:     cfg_d.bit_width            = cfg_data_i[BW_W-1:0];
        REG_CHANNEL_COUNT: cfg_d.channel_count        = cfg_data_i[CCNT_W-1:0];
        REG_ELEMS_PER_CH:  cfg_d.elements_per_channel = cfg_data_i[EPC_W-1:0];
        REG_TABLE_STRIDE:  cfg_d.table_stride         = cfg_data_i[STRIDE_W-1:0];
        REG_ALT_AXIS:      cfg_d.alternate_axis       = cfg_data_i[0];
        REG_TOTAL_INDICES: cfg_d.total_indices        = cfg_data_i[TOTAL_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_width            <= BW_W'(4);
      cfg_q.channel_count        <= CCNT_W'(1);
      cfg_q.elements_per_channel <= EPC_W'(1);
      cfg_q.table_stride         <= STRIDE_W'(16);
      cfg_q.alternate_axis       <= 1'b0;
      cfg_q.total_indices        <= TOTAL_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  plid_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_command_i       (in_command_i),
    .in_table_address_i (in_table_address_i),
    .in_table_word_i    (in_table_word_i),
    .in_stream_byte_i   (in_stream_byte_i),
    .qctl_o             (qctl),
    .q_full_i           (q_full),
    .push_op_o          (push_op)
  );

  plid_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (qctl.push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .pop_op_o  (pop_op)
  );

  plid_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .op_valid_i           (q_valid),
    .op_i                 (pop_op),
    .pop_o                (q_pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_value_o          (out_value_o),
    .out_channel_o        (out_channel_o),
    .out_last_of_byte_o   (out_last_of_byte_o),
    .out_last_of_tensor_o (out_last_of_tensor_o)
  );

  // The front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qctl.push && qctl.full))
    else $error("operation pushed into full queue");

  // The back end only pops what is there
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("operation popped from empty queue");

  // The tensor's final result also closes its word
  a_tensor_end_closes_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_of_tensor_o) |-> out_last_of_byte_o)
    else $error("tensor end without word end");

endmodule

@@ rtl/plid_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module plid_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/plid_front.sv @@
// Front end: takes words, unpacks indices and queues store operations.
module plid_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  plid_pkg::plid_cfg_t           cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          in_command_i,
  input  logic [plid_pkg::TADDR_W-1:0]  in_table_address_i,
  input  logic [plid_pkg::WORD_W-1:0]   in_table_word_i,
  input  logic [plid_pkg::BYTE_W-1:0]   in_stream_byte_i,
  output plid_pkg::plid_qctl_t          qctl_o,
  input  logic                          q_full_i,
  output plid_pkg::plid_op_t            push_op_o
);
  import plid_pkg::*;

  // Item in work and unpacking state
  logic                busy_q, busy_d;
  plid_cmd_e           kind_q, kind_d;
  logic [ADDR_W-1:0]   waddr_q, waddr_d;
  logic [WORD_W-1:0]   wword_q, wword_d;
  logic [BUF_W-1:0]    buf_q, buf_d;
  logic [HELD_W-1:0]   held_q, held_d;
  logic [RCNT_W-1:0]   cnt_q, cnt_d;
  logic [CHAN_W-1:0]   chan_q, chan_d;
  logic [EPC_W-1:0]    elem_q, elem_d;
  logic [TOTAL_W-1:0]  done_q, done_d;

  logic [WID_W-1:0]         w;
  logic [HELD_W-1:0]        w_h;
  logic [CCNT_W-1:0]        ch_eff;
  logic [EPC_W-1:0]         epc_eff;
  logic [TOTAL_W-1:0]       total_eff;
  logic [MAX_BIT_WIDTH-1:0] mask;
  logic [HELD_W-1:0]        shift;
  logic [BUF_W-1:0]         shifted;
  logic [MAX_BIT_WIDTH-1:0] idx;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        addr_sum;
  logic [TOTAL_W:0]         done_inc;
  logic [CCNT_W-1:0]        chan_inc;
  logic [EPC_W:0]           elem_inc;
  logic [CHAN_W-1:0]        chan_next;
  logic                     last;
  logic [HELD_W-1:0]        held_post;
  logic [HELD_W-1:0]        held_now;
  logic [HELD_W-1:0]        held_acc;
  logic                     cont;
  logic                     emit;
  logic                     wr_push;
  logic                     item_done;
  logic                     accept;

  // Effective configuration values
  always_comb begin
    if (cfg_i.bit_width == '0) begin
      w = WID_W'(1);
    end else if (int'(cfg_i.bit_width) > MAX_BIT_WIDTH) begin
      w = WID_W'(MAX_BIT_WIDTH);
    end else begin
      w = WID_W'(cfg_i.bit_width);
    end
    if (cfg_i.channel_count == '0) begin
      ch_eff = CCNT_W'(1);
    end else if (int'(cfg_i.channel_count) > CHAN_LIMIT) begin
      ch_eff = CCNT_W'(CHAN_LIMIT);
    end else begin
      ch_eff = cfg_i.channel_count;
    end
    epc_eff   = (cfg_i.elements_per_channel == '0) ? EPC_W'(1) : cfg_i.elements_per_channel;
    total_eff = (cfg_i.total_indices == '0) ? TOTAL_W'(1) : cfg_i.total_indices;
  end

  assign w_h = HELD_W'(w);

  // Index extraction, most significant bit first
  assign mask     = ~({MAX_BIT_WIDTH{1'b1}} << w);
  assign shift    = held_q - w_h;
  assign shifted  = buf_q >> shift;
  assign idx      = shifted[MAX_BIT_WIDTH-1:0] & mask;

  // Store address of the current channel's entry, wrapped to the depth
  assign prod     = chan_q * cfg_i.table_stride;
  assign addr_sum = prod + PROD_W'(idx);

  // Counter arithmetic
  assign done_inc  = {1'b0, done_q} + 1'b1;
  assign last      = (done_inc >= {1'b0, total_eff});
  assign chan_inc  = {1'b0, chan_q} + 1'b1;
  assign chan_next = (chan_inc >= ch_eff) ? '0 : chan_inc[CHAN_W-1:0];
  assign elem_inc  = {1'b0, elem_q} + 1'b1;

  // Step control
  assign emit      = busy_q && (kind_q == CMD_STREAM_BYTE) && !q_full_i;
  assign wr_push   = busy_q && (kind_q == CMD_TABLE_WRITE) && !q_full_i;
  assign held_post = last ? '0 : (held_q - w_h);
  assign cont      = !last && (held_post >= w_h) && (cnt_q != RCNT_W'(MAX_RESULTS - 1));
  assign item_done = wr_push || (emit && !cont);
  assign in_stall_o = busy_q && !item_done;
  assign accept    = in_valid_i && !in_stall_o;
  assign held_now  = emit ? held_post : held_q;
  assign held_acc  = held_now + HELD_W'(BYTE_W);

  // Queued operation
  always_comb begin
    push_op_o                = '0;
    push_op_o.kind           = kind_q;
    if (kind_q == CMD_TABLE_WRITE) begin
      push_op_o.addr         = waddr_q;
      push_op_o.word         = wword_q;
    end else begin
      push_op_o.addr         = addr_sum[ADDR_W-1:0];
      push_op_o.chan         = chan_q;
      push_op_o.last_of_byte = !cont;
      push_op_o.last_of_tensor = last;
    end
  end

  assign qctl_o.push = emit || wr_push;
  assign qctl_o.full = q_full_i;

  // Next state
  always_comb begin
    busy_d  = busy_q;
    kind_d  = kind_q;
    waddr_d = waddr_q;
    wword_d = wword_q;
    buf_d   = buf_q;
    held_d  = held_q;
    cnt_d   = cnt_q;
    chan_d  = chan_q;
    elem_d  = elem_q;
    done_d  = done_q;

    if (emit) begin
      held_d = held_post;
      cnt_d  = cnt_q + 1'b1;
      if (last) begin
        chan_d = '0;
        elem_d = '0;
        done_d = '0;
      end else begin
        done_d = done_inc[TOTAL_W-1:0];
        if (cfg_i.alternate_axis) begin
          chan_d = chan_next;
        end else if (elem_inc >= {1'b0, epc_eff}) begin
          elem_d = '0;
          chan_d = chan_next;
        end else begin
          elem_d = elem_inc[EPC_W-1:0];
        end
      end
    end

    if (item_done) begin
      busy_d = 1'b0;
    end

    if (accept) begin
      cnt_d = '0;
      if (in_command_i == CMD_TABLE_WRITE) begin
        kind_d  = CMD_TABLE_WRITE;
        busy_d  = 1'b1;
        waddr_d = ADDR_W'(in_table_address_i);
        wword_d = in_table_word_i;
      end else begin
        kind_d  = CMD_STREAM_BYTE;
        buf_d   = BUF_W'({buf_q, in_stream_byte_i});
        held_d  = held_acc;
        busy_d  = (held_acc >= w_h);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kind_q <= CMD_TABLE_WRITE;
      held_q <= '0;
      cnt_q  <= '0;
      chan_q <= '0;
      elem_q <= '0;
      done_q <= '0;
      buf_q  <= '0;
    end else begin
      busy_q <= busy_d;
      kind_q <= kind_d;
      held_q <= held_d;
      cnt_q  <= cnt_d;
      chan_q <= chan_d;
      elem_q <= elem_d;
      done_q <= done_d;
      buf_q  <= buf_d;
    end
  end

  // Payload of a pending store write
  always_ff @(posedge clk_i) begin
    waddr_q <= waddr_d;
    wword_q <= wword_d;
  end

endmodule

@@ rtl/plid_queue.sv @@
// Short operation queue between the front and back ends.
module plid_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  plid_pkg::plid_op_t  push_op_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output plid_pkg::plid_op_t  pop_op_o
);
  import plid_pkg::*;

  plid_op_t            entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o   = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o  = (count_q != '0);
  assign pop_op_o = entries_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

@@ rtl/plid_back.sv @@
// Back end: runs queued operations on the value store and drives results.
module plid_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         op_valid_i,
  input  plid_pkg::plid_op_t           op_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [plid_pkg::WORD_W-1:0]  out_value_o,
  output logic [plid_pkg::CHAN_W-1:0]  out_channel_o,
  output logic                         out_last_of_byte_o,
  output logic                         out_last_of_tensor_o
);
  import plid_pkg::*;

  logic                 ram_we;
  logic                 ram_re;
  logic [WORD_W-1:0]    ram_rdata;

  // Read stage, aligned with the registered store data
  logic                 s1_valid_q, s1_valid_d;
  logic [CHAN_W-1:0]    s1_chan_q;
  logic                 s1_lob_q;
  logic                 s1_lot_q;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [WORD_W-1:0]    out_value_q;
  logic [CHAN_W-1:0]    out_chan_q;
  logic                 out_lob_q;
  logic                 out_lot_q;

  logic                 out_free;
  logic                 s1_move;
  logic                 s1_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_move  = s1_valid_q && out_free;
  assign s1_free  = !s1_valid_q || out_free;

  // Writes retire at once; reads need room in the read stage
  assign pop_o  = op_valid_i && ((op_i.kind == CMD_TABLE_WRITE) || s1_free);
  assign ram_we = pop_o && (op_i.kind == CMD_TABLE_WRITE);
  assign ram_re = pop_o && (op_i.kind == CMD_STREAM_BYTE);

  plid_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (op_i.addr),
    .wdata_i (op_i.word),
    .re_i    (ram_re),
    .raddr_i (op_i.addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (ram_re) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s1_chan_q <= op_i.chan;
      s1_lob_q  <= op_i.last_of_byte;
      s1_lot_q  <= op_i.last_of_tensor;
    end
    if (s1_move) begin
      out_value_q <= ram_rdata;
      out_chan_q  <= s1_chan_q;
      out_lob_q   <= s1_lob_q;
      out_lot_q   <= s1_lot_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_value_o          = out_value_q;
  assign out_channel_o        = out_chan_q;
  assign out_last_of_byte_o   = out_lob_q;
  assign out_last_of_tensor_o = out_lot_q;

endmodule

@@ verif/plid_lut_checker.sv @@
// Checker for the packed index table decompressor: predicts every table value word and compares.
`timescale 1ns / 1ps

module plid_lut_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [plid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [plid_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            in_command_i,
  input  logic [plid_pkg::TADDR_W-1:0]    in_table_address_i,
  input  logic [plid_pkg::WORD_W-1:0]     in_table_word_i,
  input  logic [plid_pkg::BYTE_W-1:0]     in_stream_byte_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [plid_pkg::WORD_W-1:0]     out_value_i,
  input  logic [plid_pkg::CHAN_W-1:0]     out_channel_i,
  input  logic                            out_last_of_byte_i,
  input  logic                            out_last_of_tensor_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o
);
  import plid_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [CHAN_W-1:0] channel;
    logic              last_of_byte;
    logic              last_of_tensor;
  } lut_result_t;

  // shadow of the value store, the registers and the unpacking state
  logic [WORD_W-1:0] store_shadow [TABLE_DEPTH];
  plid_cfg_t         shadow_cfg;
  logic [23:0]       bit_buf;
  int unsigned       bits_held;
  int unsigned       cur_chan;
  int unsigned       elem_in_chan;
  int unsigned       idx_done;
  lut_result_t       expected_values[$];

  // unpack one stream word into the table values it selects
  task automatic unpack_stream_word(input logic [BYTE_W-1:0] b);
    int unsigned w;
    int unsigned n_chan;
    int unsigned epc;
    int unsigned total;
    int unsigned idx;
    int unsigned addr;
    int unsigned n;
    bit          tensor_end;
    lut_result_t burst [MAX_RESULTS];
    lut_result_t r;

    w = (shadow_cfg.bit_width == 0) ? 1 : shadow_cfg.bit_width;
    if (w > MAX_BIT_WIDTH) w = MAX_BIT_WIDTH;
    n_chan = (shadow_cfg.channel_count == 0) ? 1 : shadow_cfg.channel_count;
    if (n_chan > CHAN_LIMIT) n_chan = CHAN_LIMIT;
    epc   = (shadow_cfg.elements_per_channel == 0) ? 1 : shadow_cfg.elements_per_channel;
    total = (shadow_cfg.total_indices == 0) ? 1 : shadow_cfg.total_indices;

    bit_buf   = {bit_buf[15:0], b};
    bits_held = bits_held + 8;
    n = 0;
    tensor_end = 1'b0;
    while (!tensor_end && bits_held >= w && n < MAX_RESULTS) begin
      idx = (bit_buf >> (bits_held - w)) & ((1 << w) - 1);
      bits_held = bits_held - w;
      addr = (cur_chan * shadow_cfg.table_stride + idx) % TABLE_DEPTH;
      burst[n].value          = store_shadow[addr];
      burst[n].channel        = cur_chan[CHAN_W-1:0];
      burst[n].last_of_byte   = 1'b0;
      burst[n].last_of_tensor = (idx_done + 1 >= total);
      n++;
      if (idx_done + 1 >= total) begin
        // tensor complete: drop leftover bits, restart counters
        tensor_end   = 1'b1;
        bit_buf      = '0;
        bits_held    = 0;
        cur_chan     = 0;
        elem_in_chan = 0;
        idx_done     = 0;
      end else begin
        idx_done++;
        if (shadow_cfg.alternate_axis) begin
          cur_chan = (cur_chan + 1 >= n_chan) ? 0 : cur_chan + 1;
        end else if (elem_in_chan + 1 >= epc) begin
          elem_in_chan = 0;
          cur_chan = (cur_chan + 1 >= n_chan) ? 0 : cur_chan + 1;
        end else begin
          elem_in_chan++;
        end
      end
    end
    bit_buf = bit_buf & ((bits_held > 0) ? ((24'd1 << bits_held) - 24'd1) : 24'd0);

    for (int i = 0; i < n; i++) begin
      r = burst[i];
      r.last_of_byte = (i == n - 1);
      expected_values.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    lut_result_t exp_r;
    if (!rst_ni) begin
      shadow_cfg.bit_width            = 3'd4;
      shadow_cfg.channel_count        = 9'd1;
      shadow_cfg.elements_per_channel = 16'd1;
      shadow_cfg.table_stride         = 10'd16;
      shadow_cfg.alternate_axis       = 1'b0;
      shadow_cfg.total_indices        = 24'd1;
      bit_buf      = '0;
      bits_held    = 0;
      cur_chan     = 0;
      elem_in_chan = 0;
      idx_done     = 0;
      expected_values.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (plid_reg_e'(cfg_index_i))
          REG_BIT_WIDTH:     shadow_cfg.bit_width            = cfg_data_i[BW_W-1:0];
          REG_CHANNEL_COUNT: shadow_cfg.channel_count        = cfg_data_i[CCNT_W-1:0];
          REG_ELEMS_PER_CH:  shadow_cfg.elements_per_channel = cfg_data_i[EPC_W-1:0];
          REG_TABLE_STRIDE:  shadow_cfg.table_stride         = cfg_data_i[STRIDE_W-1:0];
          REG_ALT_AXIS:      shadow_cfg.alternate_axis       = cfg_data_i[0];
          REG_TOTAL_INDICES: shadow_cfg.total_indices        = cfg_data_i[TOTAL_W-1:0];
          default: ;
        endcase
      end

      // accepted input word
      if (in_valid_i && !in_stall_i) begin
        if (in_command_i == CMD_TABLE_WRITE) begin
          store_shadow[in_table_address_i] = in_table_word_i;
        end else begin
          unpack_stream_word(in_stream_byte_i);
        end
      end

      // accepted output word against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_values.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected output word, value %h channel %0d", $time,
                     out_value_i, out_channel_i);
          fail_count_o++;
        end else begin
          exp_r = expected_values.pop_front();
          checked_o++;
          if (out_value_i !== exp_r.value || out_channel_i !== exp_r.channel ||
              out_last_of_byte_i !== exp_r.last_of_byte ||
              out_last_of_tensor_i !== exp_r.last_of_tensor) begin
            if (fail_count_o < 10)
              $display("%0t: mismatch value %h/%h channel %0d/%0d lob %b/%b lot %b/%b (got/exp)",
                       $time, out_value_i, exp_r.value, out_channel_i, exp_r.channel,
                       out_last_of_byte_i, exp_r.last_of_byte,
                       out_last_of_tensor_i, exp_r.last_of_tensor);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_values.size();
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the packed index table decompressor: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb_top;
  import plid_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 5;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_WORDS   = 43;
  // filled store entries: a low window plus the top few for wrapped addresses
  localparam int FILL_LOW      = 160;
  localparam int FILL_HIGH     = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  in_command_i;
  logic [TADDR_W-1:0]    in_table_address_i;
  logic [WORD_W-1:0]     in_table_word_i;
  logic [BYTE_W-1:0]     in_stream_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [WORD_W-1:0]     out_value_o;
  logic [CHAN_W-1:0]     out_channel_o;
  logic                  out_last_of_byte_o;
  logic                  out_last_of_tensor_o;

  bit          no_idle;
  bit          hold_req;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned stream_words;
  int unsigned table_writes;
  int unsigned settings;
  int unsigned last_chans;

  packed_index_lut_decompressor_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .in_command_i         (in_command_i),
    .in_table_address_i   (in_table_address_i),
    .in_table_word_i      (in_table_word_i),
    .in_stream_byte_i     (in_stream_byte_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_value_o          (out_value_o),
    .out_channel_o        (out_channel_o),
    .out_last_of_byte_o   (out_last_of_byte_o),
    .out_last_of_tensor_o (out_last_of_tensor_o)
  );

  plid_lut_checker u_lut_check (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_i           (in_stall_o),
    .in_command_i         (in_command_i),
    .in_table_address_i   (in_table_address_i),
    .in_table_word_i      (in_table_word_i),
    .in_stream_byte_i     (in_stream_byte_i),
    .out_valid_i          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_value_i          (out_value_o),
    .out_channel_i        (out_channel_o),
    .out_last_of_byte_i   (out_last_of_byte_o),
    .out_last_of_tensor_i (out_last_of_tensor_o),
    .fail_count_o         (fail_count),
    .pending_o            (pending),
    .checked_o            (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one input word and hold it until it is taken
  task automatic send_word(input plid_cmd_e cmd, input logic [TADDR_W-1:0] addr,
                           input logic [WORD_W-1:0] word, input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_command_i       <= cmd;
    in_table_address_i <= addr;
    in_table_word_i    <= word;
    in_stream_byte_i   <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (cmd == CMD_TABLE_WRITE) table_writes++;
    else stream_words++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    send_word(CMD_STREAM_BYTE, TADDR_W'($urandom), {$urandom, $urandom}, b);
  endtask

  task automatic send_table(input logic [TADDR_W-1:0] addr, input logic [WORD_W-1:0] word);
    send_word(CMD_TABLE_WRITE, addr, word, BYTE_W'($urandom));
  endtask

  // stop offering, wait for every predicted word, then let the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input plid_reg_e idx, input int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(val);
    @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned bw, input int unsigned ch,
                            input int unsigned epc, input int unsigned stride,
                            input int unsigned alt, input int unsigned total);
    wait_idle();
    write_reg(REG_BIT_WIDTH, bw);
    write_reg(REG_CHANNEL_COUNT, ch);
    write_reg(REG_ELEMS_PER_CH, epc);
    write_reg(REG_TABLE_STRIDE, stride);
    write_reg(REG_ALT_AXIS, alt);
    write_reg(REG_TOTAL_INDICES, total);
    cfg_we_i <= 1'b0;
    settings++;
    last_chans = (ch == 0) ? 1 : ((ch > CHAN_LIMIT) ? CHAN_LIMIT : ch);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned len;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      len = pick_gap();
      if (len != 0) begin
        out_stall_i <= 1'b1;
        repeat (len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d words outstanding",
                 STALL_LIMIT, pending);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned bw;
    int unsigned ch;
    int unsigned epc;
    int unsigned total;
    int unsigned r;
    int unsigned w_e;
    int unsigned c_e;
    int unsigned span;
    int unsigned max_stride;
    logic [WORD_W-1:0] word;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= REG_BIT_WIDTH;
    cfg_data_i         <= '0;
    in_valid_i         <= 1'b0;
    in_command_i       <= CMD_TABLE_WRITE;
    in_table_address_i <= '0;
    in_table_word_i    <= '0;
    in_stream_byte_i   <= '0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    stream_words = 0;
    table_writes = 0;
    settings     = 0;
    last_chans   = 1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the low window and the top entries; every read below lands inside them
    for (int a = 0; a < FILL_LOW; a++) begin
      word = (a == 0) ? '1 : {$urandom, $urandom};
      send_table(TADDR_W'(a), word);
    end
    for (int a = TABLE_DEPTH - FILL_HIGH; a < TABLE_DEPTH; a++) begin
      word = (a == TABLE_DEPTH - 1) ? '0 : {$urandom, $urandom};
      send_table(TADDR_W'(a), word);
    end

    // reset settings: width 4, single index tensor, end drops the rest of the word
    send_byte(8'hFF);
    send_byte(8'h00);

    // width 1, largest counts and stride, store rewritten mid-stream
    set_config(1, 256, 65535, 1023, 0, 24'hFFFFFF);
    send_byte(8'hA5);
    send_table(10'd1, '1);
    send_byte(8'h5A);
    send_byte(8'hFF);

    // width 7, channel count above the limit, alternate axis, stride wraps the address;
    // the first index ends the tensor left over from before
    set_config(7, 511, 2, 1023, 1, 5);
    send_byte(8'hFE);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(8'hC3);

    // zero registers are taken as their minimum
    set_config(0, 0, 0, 0, 0, 0);
    send_byte(8'h80);
    send_byte(8'h7F);

    // channel left past a reduced count is used once, then wraps
    set_config(3, 8, 1, 60, 1, 1000);
    send_byte(8'h3C);
    set_config(3, 2, 1, 60, 1, 1000);
    send_byte(8'h99);

    // normal order, channel steps every two indices
    set_config(2, 4, 2, 5, 0, 24'hFFFFFF);
    send_byte(8'hE4);
    send_byte(8'h1B);
    send_byte(8'hC6);

    // width 5, short tensor
    set_config(5, 3, 3, 7, 0, 7);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h78);
    send_byte(8'h9A);

    // stride just below the depth: channel one reads the top entries and wraps to zero
    set_config(4, 2, 1, 1020, 0, 6);
    send_byte(8'h01);
    send_byte(8'h23);
    send_byte(8'h4F);

    // random phases, each with its own settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      r  = $urandom_range(0, 9);
      bw = (r == 0) ? 0 : $urandom_range(1, 7);
      r  = $urandom_range(0, 9);
      if (r < 6) ch = $urandom_range(1, 8);
      else if (r == 6) ch = 0;
      else if (r == 7) ch = 256;
      else if (r == 8) ch = $urandom_range(257, 511);
      else ch = $urandom_range(9, 255);
      r   = $urandom_range(0, 9);
      epc = (r < 7) ? $urandom_range(1, 6) : ((r == 7) ? 0 : $urandom_range(7, 65535));
      r   = $urandom_range(0, 9);
      if (r < 7) total = $urandom_range(2, 40);
      else if (r == 7) total = $urandom_range(0, 1);
      else total = $urandom_range(41, 24'hFFFFFF);

      // bound the stride so the highest channel, left-over one included, stays in the window
      w_e  = (bw == 0) ? 1 : bw;
      c_e  = (ch == 0) ? 1 : ((ch > CHAN_LIMIT) ? CHAN_LIMIT : ch);
      span = (c_e > last_chans) ? c_e : last_chans;
      max_stride = (span > 1) ? (FILL_LOW - (1 << w_e)) / (span - 1) : TABLE_DEPTH - 1;
      if (max_stride > TABLE_DEPTH - 1) max_stride = TABLE_DEPTH - 1;
      set_config(bw, ch, epc, $urandom_range(0, max_stride), $urandom_range(0, 1), total);

      no_idle = (ph == 3);
      if (ph == 1) hold_req = 1'b1;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(0, 99) < 15)
          send_table(TADDR_W'($urandom_range(0, FILL_LOW - 1)), {$urandom, $urandom});
        else
          send_byte(BYTE_W'($urandom));
      end
      no_idle = 1'b0;
    end

    wait_idle();
    $display("Run covered %0d stream words and %0d table writes, %0d output words checked.",
             stream_words, table_writes, checked);
    $display("Settings applied: %0d, including widths 1 to 7, both channel orders and limits.",
             settings);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ packed_index_lut_decompressor_top.f @@
rtl/plid_pkg.sv
rtl/plid_ram.sv
rtl/plid_front.sv
rtl/plid_queue.sv
rtl/plid_back.sv
rtl/packed_index_lut_decompressor_top.sv
verif/plid_lut_checker.sv
verif/tb_top.sv
